// ===== design/nibble_radix_trie_map_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the nibble radix trie map unit
// Shared clocked property forms; each use stands on a line of its own.
// ----------------------------------------------------------------------------
`ifndef NIBBLE_RADIX_TRIE_MAP_UNIT_MACROS_SVH
`define NIBBLE_RADIX_TRIE_MAP_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define NRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nrt: same-cycle check failed");

// next-cycle implication, disabled during reset
`define NRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nrt: next-cycle check failed");

`endif

// ===== design/nrt_pkg.sv =====
// ----------------------------------------------------------------------------
// nrt_pkg
// Types and constants shared by the trie map unit and its submodules.
// ----------------------------------------------------------------------------
package nrt_pkg;

    localparam int NRT_POOL_NODES = 1024;
    localparam int NODE_WORDS     = 16;
    localparam int NIB_W          = 4;
    localparam int KEY_W          = 32;
    localparam int VAL_W          = 32;
    localparam int LEVELS         = KEY_W / NIB_W;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [KEY_W-1:0] key;
        logic             op;
    } t_req;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic             status;
    } t_res;

endpackage

// ===== design/nrt_ram.sv =====
// ----------------------------------------------------------------------------
// nrt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/nrt_walk.sv =====
// ----------------------------------------------------------------------------
// nrt_walk
// Trie walk sequencer: one shared address adder and link compare, node pool.
// ----------------------------------------------------------------------------
`include "nibble_radix_trie_map_unit_macros.svh"

module nrt_walk #(
    parameter int POOL_NODES = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  nrt_pkg::t_req i_req,
    output logic          o_idle,
    output logic          o_done,
    output nrt_pkg::t_res o_res,
    input  logic          i_take
);
    import nrt_pkg::*;

    localparam int AW = $clog2(POOL_NODES * NODE_WORDS);
    localparam int NW = $clog2(POOL_NODES + 1);
    localparam int LW = $clog2(LEVELS);
    localparam logic [LW-1:0] LastLevel = LW'(LEVELS - 1);
    localparam logic [NW-1:0] PoolFull  = NW'(POOL_NODES);
    localparam logic [VAL_W-1:0] LinkMax = VAL_W'(POOL_NODES * NODE_WORDS - NODE_WORDS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_CLR  = 3'd3;
    localparam logic [2:0] S_LNK  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [LW-1:0]    r_level, n_level;
    logic [NW-1:0]    r_next_node, n_next_node;
    logic [NIB_W-1:0] r_clr, n_clr;
    logic [AW-1:0]    r_node, n_node;
    logic [AW-1:0]    r_slot, n_slot;
    logic [KEY_W-1:0] r_key, n_key;
    logic             r_op, n_op;
    logic [VAL_W-1:0] r_value, n_value;
    t_res             r_res, n_res;
    logic             r_rootz, n_rootz;
    logic [NODE_WORDS-1:0] r_root_vld, n_root_vld;

    logic [NIB_W-1:0] offset;
    logic [AW-1:0]    addr_sum;
    logic [VAL_W-1:0] rdata;
    logic [VAL_W-1:0] link;
    logic             link_ok;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;

    // shared address adder: node base plus nibble or clear offset
    assign offset   = (r_state == S_CLR) ? r_clr : r_key[KEY_W-1 -: NIB_W];
    assign addr_sum = r_node + AW'(offset);

    // root words read as zero until first written
    assign link    = r_rootz ? '0 : rdata;
    assign link_ok = (link != '0) && (link <= LinkMax);

    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_next_node = r_next_node;
        n_clr       = r_clr;
        n_node      = r_node;
        n_slot      = r_slot;
        n_key       = r_key;
        n_op        = r_op;
        n_value     = r_value;
        n_res       = r_res;
        n_rootz     = r_rootz;
        we          = 1'b0;
        waddr       = r_slot;
        wdata       = r_value;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key   = i_req.key;
                    n_op    = i_req.op;
                    n_value = i_req.value;
                    n_node  = '0;
                    n_level = '0;
                    n_res   = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_slot  = addr_sum;
                n_rootz = (addr_sum[AW-1:NIB_W] == '0) && !r_root_vld[addr_sum[NIB_W-1:0]];
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_level == LastLevel) begin
                    if (r_op == OP_GET) begin
                        n_res.read_value = link;
                    end else begin
                        we = 1'b1;
                    end
                    n_state = S_DONE;
                end else if (link_ok) begin
                    n_node  = link[AW-1:0];
                    n_level = r_level + 1'b1;
                    n_key   = r_key << NIB_W;
                    n_state = S_RD;
                end else if (r_op == OP_GET) begin
                    n_state = S_DONE;
                end else if (r_next_node == PoolFull) begin
                    n_res.status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_node      = {r_next_node[AW-NIB_W-1:0], NIB_W'(0)};
                    n_next_node = r_next_node + 1'b1;
                    n_clr       = '0;
                    n_state     = S_CLR;
                end
            end
            S_CLR: begin
                we    = 1'b1;
                waddr = addr_sum;
                wdata = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_LNK;
                end
            end
            S_LNK: begin
                we      = 1'b1;
                wdata   = VAL_W'(r_node);
                n_level = r_level + 1'b1;
                n_key   = r_key << NIB_W;
                n_state = S_RD;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_root_vld = r_root_vld;
        if (we && (waddr[AW-1:NIB_W] == '0)) begin
            n_root_vld[waddr[NIB_W-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_next_node <= NW'(1);
            r_root_vld  <= '0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_next_node <= n_next_node;
            r_root_vld  <= n_root_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clr   <= n_clr;
        r_node  <= n_node;
        r_slot  <= n_slot;
        r_key   <= n_key;
        r_op    <= n_op;
        r_value <= n_value;
        r_res   <= n_res;
        r_rootz <= n_rootz;
    end

    nrt_ram #(
        .WIDTH(VAL_W),
        .DEPTH(POOL_NODES * NODE_WORDS)
    ) u_pool (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(addr_sum),
        .o_rdata(rdata)
    );

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

    `NRT_ASSERT_IMP(a_pool_bound, i_clk, i_rst_n, 1'b1, r_next_node <= PoolFull)
    `NRT_ASSERT_IMP(a_full_only_set, i_clk, i_rst_n, o_done && (r_res.status == ST_FULL), r_op == OP_SET)
    `NRT_ASSERT_IMP(a_set_reads_zero, i_clk, i_rst_n, o_done && (r_op == OP_SET), r_res.read_value == '0)
    `NRT_ASSERT_NXT(a_link_descends, i_clk, i_rst_n, r_state == S_LNK, (r_state == S_RD) && (r_level == $past(r_level) + 1'b1))

endmodule

// ===== design/nibble_radix_trie_map_unit.sv =====
// Per trie level walked: read the slot (S_RD), then check the link (S_CHK). Per node
// allocated (a set can allocate all seven interior nodes): clear it (S_CLR), then link
// it (S_LNK); the result waits in S_DONE for the output register. Words go one at a time:
// the next is taken when the walk is idle (single pool read port, one-word-per-cycle clear).
// Reset (synchronous, active low): root node reads as zero, free pointer at the first
// node after the root, output empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
// nibble_radix_trie_map_unit
// Sparse 32-bit key to 32-bit value map held as a 16-way radix trie in a
// fixed node pool; get and set words on a stream interface.
// ----------------------------------------------------------------------------
module nibble_radix_trie_map_unit #(
    parameter int POOL_NODES = nrt_pkg::NRT_POOL_NODES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave side
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [nrt_pkg::KEY_W+nrt_pkg::VAL_W-1:0] s_axis_tdata, // key, value
    input  logic                        s_axis_tuser,  // op
    // master side
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [nrt_pkg::VAL_W-1:0]   m_axis_tdata,  // read_value
    output logic                        m_axis_tuser   // status
);
    import nrt_pkg::*;

    logic  start;
    logic  idle;
    logic  done;
    logic  take;
    t_req  req;
    t_res  res;
    logic  r_out_vld;
    t_res  r_out;

    // accept a word whenever the walker is idle; a finished result may still wait
    assign s_axis_tready = idle;
    assign start         = s_axis_tvalid && s_axis_tready;

    assign req.op    = s_axis_tuser;
    assign req.key   = s_axis_tdata[KEY_W-1:0];
    assign req.value = s_axis_tdata[KEY_W+VAL_W-1:KEY_W];

    nrt_walk #(
        .POOL_NODES(POOL_NODES)
    ) u_walk (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_req  (req),
        .o_idle (idle),
        .o_done (done),
        .o_res  (res),
        .i_take (take)
    );

    // output register: load when empty or draining this cycle
    assign take = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (done && take) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && take) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out.read_value;
    assign m_axis_tuser  = r_out.status;

endmodule

// ===== tb/sv/nibble_radix_trie_map_checker.sv =====
// ----------------------------------------------------------------------------
// nibble_radix_trie_map_checker
// Watches both stream channels of the trie map unit. Keeps its own trie and
// free pointer, works out the reply to every accepted request, and compares
// each reply field by field against the oldest outstanding one.
// ----------------------------------------------------------------------------
module nibble_radix_trie_map_checker #(
    parameter int POOL_NODES = nrt_pkg::NRT_POOL_NODES
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    input  logic                                     s_axis_tready,
    input  logic [nrt_pkg::KEY_W+nrt_pkg::VAL_W-1:0] s_axis_tdata,  // key, value
    input  logic                                     s_axis_tuser,  // op
    input  logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    input  logic [nrt_pkg::VAL_W-1:0]                m_axis_tdata,  // read_value
    input  logic                                     m_axis_tuser,  // status
    output int                                       o_fail_count,
    output int                                       o_pending
);

    localparam int          NODE_WORDS = nrt_pkg::NODE_WORDS;
    localparam int          POOL_WORDS = POOL_NODES * NODE_WORDS;
    localparam int unsigned TOP_SHIFT  = nrt_pkg::KEY_W - nrt_pkg::NIB_W;
    localparam logic [31:0] NIB_MASK   = 32'hF;

    typedef struct {
        nrt_pkg::t_res             res;
        logic                      op;
        logic [nrt_pkg::KEY_W-1:0] key;
    } t_lookup;

    logic [nrt_pkg::VAL_W-1:0] trie_words [POOL_WORDS];
    int unsigned               free_word;
    t_lookup                   pending_lookups [$];
    int                        fail_count;

    // Walk the key from its top nibble down; a set grows missing nodes from
    // the free pointer and gives up with a full status when none is left.
    task automatic trie_access(input logic op, input logic [31:0] key,
                               input logic [31:0] value, output nrt_pkg::t_res res);
        int unsigned node;
        int unsigned slot;
        int unsigned shift;
        logic [31:0] link;
        bit          found;
        node           = 0;
        found          = 1'b1;
        res.read_value = '0;
        res.status     = nrt_pkg::ST_DONE;
        for (shift = TOP_SHIFT; shift != 0; shift -= nrt_pkg::NIB_W) begin
            slot = node + ((key >> shift) & NIB_MASK);
            link = trie_words[slot];
            // a link outside the pool, or zero, means no child here
            if (link == 0 || link > POOL_WORDS - NODE_WORDS) begin
                if (op == nrt_pkg::OP_GET) begin
                    found = 1'b0;
                    break;
                end
                if (free_word + NODE_WORDS > POOL_WORDS) begin
                    res.status = nrt_pkg::ST_FULL;
                    found      = 1'b0;
                    break;
                end
                link = free_word;
                for (int w = 0; w < NODE_WORDS; w++) trie_words[free_word + w] = '0;
                free_word        += NODE_WORDS;
                trie_words[slot]  = link;
            end
            node = link;
        end
        if (found) begin
            slot = node + (key & NIB_MASK);
            if (op == nrt_pkg::OP_GET) res.read_value = trie_words[slot];
            else trie_words[slot] = value;
        end
    endtask

    initial begin
        fail_count   = 0;
        free_word    = NODE_WORDS;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_lookup       want;
        nrt_pkg::t_res got;
        if (!i_rst_n) begin
            for (int w = 0; w < NODE_WORDS; w++) trie_words[w] = '0;
            free_word = NODE_WORDS;
            pending_lookups.delete();
        end else begin
            // retire the reply first so it can never pair with a request of this edge
            if (m_axis_tvalid && m_axis_tready) begin
                got.read_value = m_axis_tdata;
                got.status     = m_axis_tuser;
                if (pending_lookups.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected reply word, expected none, got value %h status %b",
                             $time, got.read_value, got.status);
                end else begin
                    want = pending_lookups.pop_front();
                    if (got.read_value !== want.res.read_value) begin
                        fail_count++;
                        $display("%0t: key %h op %b read_value expected %h got %h", $time,
                                 want.key, want.op, want.res.read_value, got.read_value);
                    end
                    if (got.status !== want.res.status) begin
                        fail_count++;
                        $display("%0t: key %h op %b status expected %b got %b", $time,
                                 want.key, want.op, want.res.status, got.status);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want.op  = s_axis_tuser;
                want.key = s_axis_tdata[nrt_pkg::KEY_W-1:0];
                trie_access(want.op, want.key,
                            s_axis_tdata[nrt_pkg::KEY_W +: nrt_pkg::VAL_W], want.res);
                pending_lookups.push_back(want);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_lookups.size();
    end

endmodule

// ===== tb/sv/nibble_radix_trie_map_unit_tb.sv =====
// ----------------------------------------------------------------------------
// nibble_radix_trie_map_unit_tb
// Drives get and set words into the trie map unit and gives the verdict.
// A directed opening covers the key extremes, absent keys, overwrites, a
// stored zero and shared paths; random traffic then reuses stored keys, keys
// that share a prefix with them and fresh keys until the node pool runs full.
// ----------------------------------------------------------------------------
module nibble_radix_trie_map_unit_tb;

    localparam int RANDOM_WORDS   = 1300;
    localparam int IDLE_PERCENT   = 15;
    localparam int RX_HOLD_CYCLES = 400;  // receiver hold-off that backs up the input
    localparam int HOLD_AT_WORD   = 100;
    localparam int CALM_FIRST     = 500;  // words in [CALM_FIRST, CALM_LAST) see no idling
    localparam int CALM_LAST      = 700;
    localparam int DRAIN_CYCLES   = 160;  // longer than a set that allocates seven nodes
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int KEY_STORE_MAX  = 256;

    logic                                     i_clk = 1'b0;
    logic                                     i_rst_n = 1'b0;
    logic                                     s_axis_tvalid = 1'b0;
    logic                                     s_axis_tready;
    logic [nrt_pkg::KEY_W+nrt_pkg::VAL_W-1:0] s_axis_tdata = '0;  // key, value
    logic                                     s_axis_tuser = 1'b0; // op
    logic                                     m_axis_tvalid;
    logic                                     m_axis_tready = 1'b0;
    logic [nrt_pkg::VAL_W-1:0]                m_axis_tdata;        // read_value
    logic                                     m_axis_tuser;        // status

    int   fail_count;
    int   pending;
    int   stall_cycles = 0;
    bit   calm_stretch = 1'b0;
    bit   rx_hold_request = 1'b0;
    bit   rx_hold_served = 1'b0;

    logic [nrt_pkg::KEY_W-1:0] stored_keys [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    nibble_radix_trie_map_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    nibble_radix_trie_map_checker trie_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Offer one request word: change inputs at the falling edge, maybe idle
    // first, then hold the word until a rising edge sees tready.
    task automatic offer_word(input logic op, input logic [31:0] key, input logic [31:0] value);
        @(negedge i_clk);
        if (!calm_stretch && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {value, key};
        do @(posedge i_clk); while (!s_axis_tready);
        // remember stored keys so later words hit existing paths
        if (op == nrt_pkg::OP_SET) begin
            if (stored_keys.size() < KEY_STORE_MAX) stored_keys.push_back(key);
            else stored_keys[$urandom_range(0, KEY_STORE_MAX - 1)] = key;
        end
    endtask

    // Receiver: stall at random, except in the calm stretch; serve the long
    // hold-off once when the sender asks for it.
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_request && !rx_hold_served) begin
                m_axis_tready = 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge i_clk);
                rx_hold_served = 1'b1;
            end else if (!i_rst_n) begin
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = calm_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("nibble_radix_trie_map_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        int unsigned kind;
        int unsigned tail;
        logic        op;
        logic [31:0] key;
        logic [31:0] value;
        logic [31:0] base;
        logic [31:0] keep_mask;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty trie: absent at the root
        offer_word(nrt_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        offer_word(nrt_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        // first set grows all seven interior nodes
        offer_word(nrt_pkg::OP_SET, 32'h0000_0000, 32'hFFFF_FFFF);
        offer_word(nrt_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
        // store zero, then read back the same answer as an absent key
        offer_word(nrt_pkg::OP_SET, 32'hFFFF_FFFF, 32'h0000_0000);
        offer_word(nrt_pkg::OP_GET, 32'hFFFF_FFFF, 32'h1234_5678);
        // overwrite an existing value
        offer_word(nrt_pkg::OP_SET, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        offer_word(nrt_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        // share the full path, differ only in the value slot
        offer_word(nrt_pkg::OP_SET, 32'h0000_000F, 32'h5A5A_5A5A);
        offer_word(nrt_pkg::OP_GET, 32'h0000_000F, 32'h0000_0000);
        offer_word(nrt_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000);
        // miss at the last link, and at the top link
        offer_word(nrt_pkg::OP_GET, 32'h0000_0010, 32'h0000_0000);
        offer_word(nrt_pkg::OP_GET, 32'h1000_0000, 32'h0000_0000);
        // branch off partway down an existing path, and at the root
        offer_word(nrt_pkg::OP_SET, 32'h0000_1000, 32'h8000_0001);
        offer_word(nrt_pkg::OP_GET, 32'h0000_1000, 32'h0000_0000);
        offer_word(nrt_pkg::OP_SET, 32'h8000_0001, 32'h8000_0000);
        offer_word(nrt_pkg::OP_GET, 32'h8000_0001, 32'h0000_0000);
        offer_word(nrt_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);

        // Random traffic: mostly stored keys and their near neighbors, some
        // fresh keys; fresh paths drain the pool until sets report it full.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            calm_stretch = (n >= CALM_FIRST && n < CALM_LAST);
            if (n == HOLD_AT_WORD) rx_hold_request = 1'b1;
            kind = $urandom_range(0, 99);
            if (stored_keys.size() == 0 || kind < 20) begin
                key = $urandom;
            end else begin
                base = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                if (kind < 55) begin
                    // keep the top nibbles, redraw the tail
                    tail      = $urandom_range(1, 7);
                    keep_mask = 32'hFFFF_FFFF << (4 * tail);
                    key       = (base & keep_mask) | ($urandom & ~keep_mask);
                end else begin
                    key = base;
                end
            end
            op = $urandom_range(0, 1) ? nrt_pkg::OP_SET : nrt_pkg::OP_GET;
            case ($urandom_range(0, 9))
                0: begin
                    value = 32'h0000_0000;
                end
                1: begin
                    value = 32'hFFFF_FFFF;
                end
                default: begin
                    value = $urandom;
                end
            endcase
            offer_word(op, key, value);
        end
        calm_stretch = 1'b0;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;

        // drain: wait for every reply, then let any stray word show up
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("nibble_radix_trie_map_unit verification clean");
        end else begin
            $display("nibble_radix_trie_map_unit verification failed");
        end
        $finish;
    end

endmodule
